// File: rtl/core/esd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// esd_pkg
// Shared types and character constants for the escape sequence decoder.
// ----------------------------------------------------------------------------
package esd_pkg;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_R       = 8'h72;
    localparam logic [7:0] CH_N       = 8'h6E;
    localparam logic [7:0] CH_T       = 8'h74;
    localparam logic [7:0] CH_X       = 8'h78;
    localparam logic [7:0] CH_0       = 8'h30;
    localparam logic [7:0] CH_9       = 8'h39;
    localparam logic [7:0] CH_LA      = 8'h61;
    localparam logic [7:0] CH_LF      = 8'h66;
    localparam logic [7:0] CH_UA      = 8'h41;
    localparam logic [7:0] CH_UF      = 8'h46;
    localparam logic [7:0] CODE_CR    = 8'h0D;
    localparam logic [7:0] CODE_LF    = 8'h0A;
    localparam logic [7:0] CODE_TAB   = 8'h09;
    localparam logic [3:0] HEX_ALPHA_OFS = 4'h9;

    typedef enum logic [2:0] {
        KIND_PLAIN,
        KIND_PERCENT,
        KIND_BSLASH,
        KIND_R,
        KIND_N,
        KIND_T,
        KIND_X
    } kind_t;

    typedef struct packed {
        logic [7:0] text;
        kind_t      kind;
        logic       hex_ok;
        logic [3:0] hex_val;
    } entry_t;

    typedef struct packed {
        entry_t ent;
        logic   eot;
    } req_t;

    typedef enum logic [1:0] {
        PAIR_WAIT,
        PAIR_FAIL,
        PAIR_OK
    } pair_st_t;

    typedef struct packed {
        pair_st_t   st;
        logic [7:0] val;
    } pair_t;

    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } bk_state_t;

endpackage
`default_nettype wire

// File: rtl/core/esd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// esd_front
// Accepts raw text bytes, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module esd_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [7:0]    s_tdata,
    input  wire logic          s_tlast,
    output logic               q_valid,
    input  wire logic          q_pop,
    output esd_pkg::req_t      q_req
);
    import esd_pkg::*;

    function automatic entry_t classify(logic [7:0] c);
        entry_t e;
        e.text    = c;
        e.hex_ok  = 1'b0;
        e.hex_val = c[3:0];
        if (c inside {[CH_0:CH_9]}) begin
            e.hex_ok = 1'b1;
        end else if (c inside {[CH_LA:CH_LF], [CH_UA:CH_UF]}) begin
            e.hex_ok  = 1'b1;
            e.hex_val = c[3:0] + HEX_ALPHA_OFS;
        end
        case (c)
            CH_PERCENT: e.kind = KIND_PERCENT;
            CH_BSLASH:  e.kind = KIND_BSLASH;
            CH_R:       e.kind = KIND_R;
            CH_N:       e.kind = KIND_N;
            CH_T:       e.kind = KIND_T;
            CH_X:       e.kind = KIND_X;
            default:    e.kind = KIND_PLAIN;
        endcase
        return e;
    endfunction

    req_t       mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    logic       pop;

    assign s_tready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_req    = mem_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_pop && q_valid;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= '{ent: classify(s_tdata), eot: s_tlast};
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/esd_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// esd_back
// Holds pending bytes, decides one escape per cycle in its run state while the
// output register is free, and drives the output register.
// ----------------------------------------------------------------------------
module esd_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          q_valid,
    output logic               q_pop,
    input  wire esd_pkg::req_t q_req,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [7:0]         m_tdata,
    output logic               m_tlast
);
    import esd_pkg::*;

    function automatic pair_t hex_pair(entry_t hi, entry_t lo, logic have_hi,
                                       logic have_lo, logic fin);
        pair_t p;
        p.val = {hi.hex_val, lo.hex_val};
        if (!have_hi) begin
            p.st = fin ? PAIR_FAIL : PAIR_WAIT;
        end else if (!hi.hex_ok) begin
            p.st = PAIR_FAIL;
        end else if (!have_lo) begin
            p.st = fin ? PAIR_FAIL : PAIR_WAIT;
        end else if (!lo.hex_ok || p.val == 8'h00) begin
            p.st = PAIR_FAIL;
        end else begin
            p.st = PAIR_OK;
        end
        return p;
    endfunction

    bk_state_t  state_reg, state_next;
    entry_t     buf_reg [4];
    entry_t     buf_next [4];
    logic [2:0] cnt_reg, cnt_next;
    logic       fin_reg, fin_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_data_reg, out_data_next;
    logic       out_last_reg, out_last_next;

    logic [2:0] used;
    logic [7:0] emit;
    logic [2:0] rem;
    logic       out_free;
    logic       fire;
    pair_t      pr;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign out_free = !out_valid_reg || m_tready;

    // decision on the front of the held buffer
    always_comb begin
        used = 3'd0;
        emit = buf_reg[0].text;
        pr   = '{st: PAIR_WAIT, val: 8'h00};
        if (buf_reg[0].kind != KIND_PERCENT && buf_reg[0].kind != KIND_BSLASH) begin
            used = 3'd1;
        end else if (cnt_reg < 3'd2) begin
            used = fin_reg ? 3'd1 : 3'd0;
        end else if (buf_reg[0].kind == KIND_PERCENT) begin
            if (buf_reg[1].kind == KIND_PERCENT) begin
                used = 3'd2;
            end else begin
                pr = hex_pair(buf_reg[1], buf_reg[2], 1'b1, cnt_reg > 3'd2, fin_reg);
                case (pr.st)
                    PAIR_OK: begin
                        used = 3'd3;
                        emit = pr.val;
                    end
                    PAIR_FAIL: used = 3'd1;
                    default:   used = 3'd0;
                endcase
            end
        end else begin
            case (buf_reg[1].kind)
                KIND_BSLASH: used = 3'd2;
                KIND_R: begin
                    used = 3'd2;
                    emit = CODE_CR;
                end
                KIND_N: begin
                    used = 3'd2;
                    emit = CODE_LF;
                end
                KIND_T: begin
                    used = 3'd2;
                    emit = CODE_TAB;
                end
                KIND_X: begin
                    pr = hex_pair(buf_reg[2], buf_reg[3], cnt_reg > 3'd2,
                                  cnt_reg > 3'd3, fin_reg);
                    case (pr.st)
                        PAIR_OK: begin
                            used = 3'd4;
                            emit = pr.val;
                        end
                        PAIR_FAIL: used = 3'd1;
                        default:   used = 3'd0;
                    endcase
                end
                default: used = 3'd1;
            endcase
        end
    end

    assign rem  = cnt_reg - used;
    assign fire = (state_reg == BK_RUN) && (used != 3'd0) && out_free;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: begin
                if (q_valid) begin
                    state_next = BK_RUN;
                end
            end
            BK_RUN: begin
                if (used == 3'd0 || (fire && rem == 3'd0)) begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        logic [3:0] idx;
        idx            = 4'd0;
        q_pop          = 1'b0;
        cnt_next       = cnt_reg;
        fin_next       = fin_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        for (int i = 0; i < 4; i++) begin
            buf_next[i] = buf_reg[i];
        end
        case (state_reg)
            BK_IDLE: begin
                if (q_valid) begin
                    q_pop                     = 1'b1;
                    buf_next[cnt_reg[1:0]]    = q_req.ent;
                    cnt_next                  = cnt_reg + 3'd1;
                    fin_next                  = q_req.eot;
                end
            end
            BK_RUN: begin
                if (fire) begin
                    out_valid_next = 1'b1;
                    out_data_next  = emit;
                    out_last_next  = fin_reg && (rem == 3'd0);
                    cnt_next       = rem;
                    for (int i = 0; i < 4; i++) begin
                        idx = 4'(i) + {1'b0, used};
                        if (idx < 4'd4) begin
                            buf_next[i] = buf_reg[idx[1:0]];
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_IDLE;
            cnt_reg       <= 3'd0;
            fin_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            fin_reg       <= fin_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        for (int i = 0; i < 4; i++) begin
            buf_reg[i] <= buf_next[i];
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/escape_sequence_decoder_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// escape_sequence_decoder_unit
// Decodes percent and backslash escapes in a byte stream.
// ----------------------------------------------------------------------------
// One text byte per request in, decoded bytes out; tlast on the input ends the
// text and flushes any pending escape, tlast on the output marks its last
// decoded byte. The front end classifies bytes into a two-entry queue; the
// back end, when idle, takes one queued byte and then emits one decoded byte
// per cycle while the output register is free; a byte that completes or
// breaks an escape yields up to four decoded bytes, and a byte that only
// extends a pending escape yields none. The result sits in an output register,
// so input is taken while it waits.
module escape_sequence_decoder_unit (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] text_byte
    input  wire logic       s_tlast,   // end_of_text
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] decoded_byte
    output logic            m_tlast    // final_byte
);
    import esd_pkg::*;

    logic q_valid;
    logic q_pop;
    req_t q_req;

    esd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_req    (q_req)
    );

    esd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_req    (q_req),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
`default_nettype wire

// File: rtl/core/esd_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// esd_checker
// Port-level checks for the escape sequence decoder.
// ----------------------------------------------------------------------------
module esd_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic [7:0] s_tdata,
    input wire logic       s_tlast,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tlast
);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // waiting request holds until taken
    a_req_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tlast))
        else $error("waiting request changed");

    // queue empty and output clear after reset
    a_rst_ready: assert property (@(posedge aclk)
        !aresetn |=> s_tready && !m_tvalid)
        else $error("reset did not clear the decoder");

    // a request needs queueing, a pop and a decision before any result
    a_rst_latency: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid ##1 !m_tvalid ##1 !m_tvalid)
        else $error("result too soon after reset");

    // no result right after reset while no request has been taken since
    a_no_spurious: assert property (@(posedge aclk)
        !aresetn ##1 !(s_tvalid && s_tready) ##1 !(s_tvalid && s_tready)
        |=> !m_tvalid)
        else $error("result without request");

endmodule

bind escape_sequence_decoder_unit esd_checker u_esd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
`default_nettype wire
